>>> src/m3i_pkg.sv
// Package of shared types, widths and cofactor lane tables for the 3x3 matrix inverter.
package m3i_pkg;

    localparam int ELEMENT_WIDTH = 16;
    localparam int FRACTION_BITS = 8;
    localparam int DET_OUT_WIDTH = 49;
    localparam int INV_WIDTH     = 32;
    localparam int INV_FRAC      = 16;
    localparam int NUM_LANES     = 9;

    typedef struct packed {
        logic signed [ELEMENT_WIDTH-1:0] a00;
        logic signed [ELEMENT_WIDTH-1:0] a01;
        logic signed [ELEMENT_WIDTH-1:0] a02;
        logic signed [ELEMENT_WIDTH-1:0] a10;
        logic signed [ELEMENT_WIDTH-1:0] a11;
        logic signed [ELEMENT_WIDTH-1:0] a12;
        logic signed [ELEMENT_WIDTH-1:0] a20;
        logic signed [ELEMENT_WIDTH-1:0] a21;
        logic signed [ELEMENT_WIDTH-1:0] a22;
    } t_in;

    typedef struct packed {
        logic signed [DET_OUT_WIDTH-1:0] det;
        logic                            singular;
        logic signed [INV_WIDTH-1:0]     i00;
        logic signed [INV_WIDTH-1:0]     i01;
        logic signed [INV_WIDTH-1:0]     i02;
        logic signed [INV_WIDTH-1:0]     i10;
        logic signed [INV_WIDTH-1:0]     i11;
        logic signed [INV_WIDTH-1:0]     i12;
        logic signed [INV_WIDTH-1:0]     i20;
        logic signed [INV_WIDTH-1:0]     i21;
        logic signed [INV_WIDTH-1:0]     i22;
    } t_out;

    // Each cofactor lane forms e[0]*e[1] - e[2]*e[3] from row-major element indexes.
    localparam int COF_IDX [NUM_LANES][4] = '{
        '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
        '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
        '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
    };

endpackage

>>> src/m3i_cof_lane.sv
// Cofactor lane: two registered products and a registered difference.
module m3i_cof_lane #(
    parameter int ELEMENT_WIDTH = m3i_pkg::ELEMENT_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [ELEMENT_WIDTH-1:0]   i_a,
    input  logic signed [ELEMENT_WIDTH-1:0]   i_d,
    input  logic signed [ELEMENT_WIDTH-1:0]   i_b,
    input  logic signed [ELEMENT_WIDTH-1:0]   i_c,
    output logic signed [2*ELEMENT_WIDTH:0]   o_cof
);

    localparam int PW = 2 * ELEMENT_WIDTH;

    logic signed [PW-1:0] r_p0;
    logic signed [PW-1:0] r_p1;
    logic signed [PW:0]   r_cof;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0  <= i_a * i_d;
            r_p1  <= i_b * i_c;
            r_cof <= (PW+1)'(r_p0) - (PW+1)'(r_p1);
        end
    end

    assign o_cof = r_cof;

endmodule

>>> src/m3i_div_lane.sv
// Pipelined restoring divider lane producing one saturated Q16.16 inverse entry.
module m3i_div_lane #(
    parameter int COF_WIDTH     = 2 * m3i_pkg::ELEMENT_WIDTH + 1,
    parameter int DET_WIDTH     = 3 * m3i_pkg::ELEMENT_WIDTH + 3,
    parameter int FRACTION_BITS = m3i_pkg::FRACTION_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [COF_WIDTH-1:0]          i_cof,
    input  logic signed [DET_WIDTH-1:0]          i_det,
    output logic signed [m3i_pkg::INV_WIDTH-1:0] o_q
);

    localparam int QW   = m3i_pkg::INV_WIDTH;
    localparam int SH   = FRACTION_BITS + m3i_pkg::INV_FRAC;
    localparam int NUMW = COF_WIDTH + SH;
    localparam int WW   = NUMW + DET_WIDTH + QW;

    logic [COF_WIDTH-1:0] cof_mag;
    logic [DET_WIDTH-1:0] det_mag;
    logic [NUMW-1:0]      num;

    logic [NUMW-1:0]      r_rem [0:QW];
    logic [DET_WIDTH-1:0] r_den [0:QW];
    logic [QW-1:0]        r_q   [0:QW];
    logic                 r_neg [0:QW];
    logic                 r_ovf [0:QW];

    always_comb begin
        cof_mag = i_cof[COF_WIDTH-1] ? COF_WIDTH'(-i_cof) : COF_WIDTH'(i_cof);
        det_mag = i_det[DET_WIDTH-1] ? DET_WIDTH'(-i_det) : DET_WIDTH'(i_det);
        num     = {cof_mag, {SH{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= num;
            r_den[0] <= det_mag;
            r_q[0]   <= '0;
            r_neg[0] <= i_cof[COF_WIDTH-1] ^ i_det[DET_WIDTH-1];
            r_ovf[0] <= WW'(num) >= (WW'(det_mag) << QW);
        end
    end

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            localparam int BIT = QW - 1 - k;
            logic [WW-1:0] sub;
            logic          take;
            always_comb begin
                sub  = WW'(r_den[k]) << BIT;
                take = WW'(r_rem[k]) >= sub;
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= take ? NUMW'(WW'(r_rem[k]) - sub) : r_rem[k];
                    r_den[k+1] <= r_den[k];
                    r_q[k+1]   <= r_q[k] | (take ? (QW'(1) << BIT) : '0);
                    r_neg[k+1] <= r_neg[k];
                    r_ovf[k+1] <= r_ovf[k];
                end
            end
        end
    endgenerate

    logic [QW-1:0] q;
    always_comb begin
        q = r_q[QW];
        if (r_neg[QW]) begin
            if (r_ovf[QW] || (q > (QW'(1) << (QW - 1)))) begin
                q = QW'(1) << (QW - 1);
            end
            o_q = $signed(-q);
        end else begin
            if (r_ovf[QW] || q[QW-1]) begin
                q = {1'b0, {(QW-1){1'b1}}};
            end
            o_q = $signed(q);
        end
    end

endmodule

>>> src/matrix3x3_inverse.sv
// 3x3 fixed-point matrix inverter: nine cofactor lanes, determinant merge, nine divider lanes.
// Each accepted input word passes the cofactor lanes, the determinant merge, the 32-stage divider
// pipelines and the output register; throughput is one word per cycle while the output is not stalled.
// The whole pipeline advances whenever the output register is empty or being taken.
// Reset clears the valid bits of every stage; data registers are not reset.
module matrix3x3_inverse #(
    parameter int ELEMENT_WIDTH = m3i_pkg::ELEMENT_WIDTH,
    parameter int FRACTION_BITS = m3i_pkg::FRACTION_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  m3i_pkg::t_in    i_in,
    output logic            o_valid,
    input  logic            i_ready,
    output m3i_pkg::t_out   o_out
);

    localparam int EW   = ELEMENT_WIDTH;
    localparam int CW   = 2 * EW + 1;
    localparam int DPW  = 3 * EW + 1;
    localparam int DW   = 3 * EW + 3;
    localparam int QW   = m3i_pkg::INV_WIDTH;
    localparam int DOW  = m3i_pkg::DET_OUT_WIDTH;
    localparam int NL   = m3i_pkg::NUM_LANES;
    localparam int DLAT = QW + 1;
    localparam int VLAT = 4 + DLAT;

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    logic signed [EW-1:0] a [0:NL-1];
    always_comb begin
        a[0] = EW'(i_in.a00);
        a[1] = EW'(i_in.a01);
        a[2] = EW'(i_in.a02);
        a[3] = EW'(i_in.a10);
        a[4] = EW'(i_in.a11);
        a[5] = EW'(i_in.a12);
        a[6] = EW'(i_in.a20);
        a[7] = EW'(i_in.a21);
        a[8] = EW'(i_in.a22);
    end

    logic [VLAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_vld   <= {r_vld[VLAT-2:0], i_valid};
            o_valid <= r_vld[VLAT-1];
        end
    end

    logic signed [CW-1:0] cof [0:NL-1];
    genvar l;
    generate
        for (l = 0; l < NL; l++) begin : g_cof
            m3i_cof_lane #(.ELEMENT_WIDTH(EW)) u_cof (
                .i_clk (i_clk),
                .i_en  (en),
                .i_a   (a[m3i_pkg::COF_IDX[l][0]]),
                .i_d   (a[m3i_pkg::COF_IDX[l][1]]),
                .i_b   (a[m3i_pkg::COF_IDX[l][2]]),
                .i_c   (a[m3i_pkg::COF_IDX[l][3]]),
                .o_cof (cof[l])
            );
        end
    endgenerate

    logic signed [EW-1:0]  r_a0_s1 [0:2];
    logic signed [EW-1:0]  r_a0_s2 [0:2];
    logic signed [DPW-1:0] r_dp    [0:2];
    logic signed [CW-1:0]  r_cof_s3 [0:NL-1];
    logic signed [CW-1:0]  r_cof_s4 [0:NL-1];
    logic signed [DW-1:0]  r_det_s4;
    logic signed [DW-1:0]  r_det_d [0:DLAT-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_a0_s1[k] <= a[k];
                r_a0_s2[k] <= r_a0_s1[k];
                r_dp[k]    <= r_a0_s2[k] * cof[k];
            end
            for (int k = 0; k < NL; k++) begin
                r_cof_s3[k] <= cof[k];
                r_cof_s4[k] <= r_cof_s3[k];
            end
            r_det_s4 <= DW'(r_dp[0]) + DW'(r_dp[1]) + DW'(r_dp[2]);
            r_det_d[0] <= r_det_s4;
            for (int k = 1; k < DLAT; k++) begin
                r_det_d[k] <= r_det_d[k-1];
            end
        end
    end

    logic signed [QW-1:0] q [0:NL-1];
    generate
        for (l = 0; l < NL; l++) begin : g_div
            m3i_div_lane #(
                .COF_WIDTH     (CW),
                .DET_WIDTH     (DW),
                .FRACTION_BITS (FRACTION_BITS)
            ) u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_cof (r_cof_s4[l]),
                .i_det (r_det_s4),
                .o_q   (q[l])
            );
        end
    endgenerate

    logic signed [DW-1:0]  det_f;
    logic signed [DOW-1:0] det_sat;
    logic                  sing;
    logic signed [QW-1:0]  inv [0:NL-1];
    localparam logic signed [DW-1:0] DMAX = DW'({1'b0, {(DOW-1){1'b1}}});
    localparam logic signed [DW-1:0] DMIN = -DMAX - DW'(1);

    always_comb begin
        det_f = r_det_d[DLAT-1];
        sing  = det_f == '0;
        if (det_f > DMAX) begin
            det_sat = DOW'(DMAX);
        end else if (det_f < DMIN) begin
            det_sat = DOW'(DMIN);
        end else begin
            det_sat = DOW'(det_f);
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                inv[r*3+c] = sing ? '0 : q[c*3+r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out.det      <= det_sat;
            o_out.singular <= sing;
            o_out.i00      <= inv[0];
            o_out.i01      <= inv[1];
            o_out.i02      <= inv[2];
            o_out.i10      <= inv[3];
            o_out.i11      <= inv[4];
            o_out.i12      <= inv[5];
            o_out.i20      <= inv[6];
            o_out.i21      <= inv[7];
            o_out.i22      <= inv[8];
        end
    end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverter.
`timescale 1ns / 1ps

module testbench;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    m3i_pkg::t_in  i_in = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    m3i_pkg::t_out o_out;

    int send_idle_pct = 0;
    int take_idle_pct = 0;
    int mismatches = 0;
    m3i_pkg::t_out inverse_queue[$];

    matrix3x3_inverse dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_in(i_in), .o_valid(o_valid), .i_ready(i_ready), .o_out(o_out)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic signed [m3i_pkg::INV_WIDTH-1:0] scaled_quotient(
        input logic signed [63:0] cof, input logic signed [63:0] det);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        num = (cof < 0 ? -cof : cof) << (m3i_pkg::FRACTION_BITS + m3i_pkg::INV_FRAC);
        den = det < 0 ? -det : det;
        q = num / den;
        if ((cof < 0) != (det < 0)) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return -q[31:0];
        end
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic m3i_pkg::t_out invert_matrix(input m3i_pkg::t_in m);
        logic signed [63:0] e[9];
        logic signed [63:0] cof[9];
        logic signed [63:0] det;
        logic signed [m3i_pkg::INV_WIDTH-1:0] inv[9];
        m3i_pkg::t_out r;
        e = '{m.a00, m.a01, m.a02, m.a10, m.a11, m.a12, m.a20, m.a21, m.a22};
        cof[0] = e[4] * e[8] - e[5] * e[7];
        cof[1] = e[5] * e[6] - e[3] * e[8];
        cof[2] = e[3] * e[7] - e[4] * e[6];
        cof[3] = e[2] * e[7] - e[1] * e[8];
        cof[4] = e[0] * e[8] - e[2] * e[6];
        cof[5] = e[1] * e[6] - e[0] * e[7];
        cof[6] = e[1] * e[5] - e[2] * e[4];
        cof[7] = e[2] * e[3] - e[0] * e[5];
        cof[8] = e[0] * e[4] - e[1] * e[3];
        det = e[0] * cof[0] + e[1] * cof[1] + e[2] * cof[2];
        r = '0;
        r.det = det[m3i_pkg::DET_OUT_WIDTH-1:0];
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        // The inverse is the transposed cofactor matrix over the determinant.
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                inv[i*3+k] = scaled_quotient(cof[k*3+i], det);
        r.i00 = inv[0]; r.i01 = inv[1]; r.i02 = inv[2];
        r.i10 = inv[3]; r.i11 = inv[4]; r.i12 = inv[5];
        r.i20 = inv[6]; r.i21 = inv[7]; r.i22 = inv[8];
        return r;
    endfunction

    task automatic send_matrix(input m3i_pkg::t_in m);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in <= m;
        inverse_queue.push_back(invert_matrix(m));
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_ready <= ($urandom_range(99) >= take_idle_pct);
            if (o_valid && i_ready) begin
                if (inverse_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h", o_out);
                end else begin
                    m3i_pkg::t_out want;
                    want = inverse_queue.pop_front();
                    if (want !== o_out) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h actual %h", want, o_out);
                    end
                end
            end
        end
    end

    function automatic m3i_pkg::t_in random_matrix(input int mode);
        logic [m3i_pkg::ELEMENT_WIDTH-1:0] v[9];
        m3i_pkg::t_in m;
        for (int k = 0; k < 9; k++) begin
            case (mode)
                0: v[k] = $urandom;
                1: v[k] = $urandom_range(1023) - 512;
                default: v[k] = $urandom_range(8) - 4;
            endcase
        end
        m = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
        // Occasionally force singularity by repeating a row.
        if ($urandom_range(9) == 0) begin
            m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
        end
        return m;
    endfunction

    task automatic test_directed();
        logic signed [15:0] one;
        one = 16'sd256;
        send_matrix('{one, 0, 0, 0, one, 0, 0, 0, one});
        send_matrix('0);
        send_matrix('{default: 16'h7FFF});
        send_matrix('{default: 16'h8000});
        send_matrix('{16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000});
        send_matrix('{16'h7FFF, 0, 0, 0, 16'h7FFF, 0, 0, 0, 16'h7FFF});
        send_matrix('{16'sd1, 0, 0, 0, 16'sd1, 0, 0, 0, 16'sd1});
        send_matrix('{16'sd1, 16'h7FFF, 0, 0, 16'sd1, 0, 0, 0, 16'sd1});
        send_matrix('{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                      16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF});
        send_matrix('{0, one, 0, -one, 0, 0, 0, 0, -one});
        send_matrix('{16'hFFFF, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hFFFF,
                      16'hF0F0, 16'h1234, 16'hFEDC, 16'hFFFF});
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) send_matrix(random_matrix($urandom_range(2)));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 26;
        take_idle_pct = 69;
        test_directed();
        test_random(180);
        send_idle_pct = 69;
        take_idle_pct = 26;
        test_random(180);
        send_idle_pct = 0;
        take_idle_pct = 0;
        test_random(180);
        i_valid <= 1'b0;
        while (inverse_queue.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

>>> matrix3x3_inverse.f
src/m3i_pkg.sv
src/m3i_cof_lane.sv
src/m3i_div_lane.sv
src/matrix3x3_inverse.sv
tb/testbench.sv
